@@ hw/rtl/nmd_pkg.sv @@
// nmd_pkg: shared types, constants and slot helpers for the neighbor max abs diff edge filter
// no dependencies; imported by the top level, the edge unit, the result fifo and the bench
`timescale 1ns / 1ps

package nmd_pkg;

    localparam int NMD_WIDTH_MAX  = 1024;
    localparam int NMD_PIXEL_BITS = 8;
    localparam int NMD_CFG_BITS   = 11;
    localparam int NMD_FIFO_DEPTH = 4;

    localparam logic [NMD_CFG_BITS-1:0] NMD_WIDTH_RESET = 11'd1024;

    typedef enum logic
    {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

    typedef logic [1:0] slot_t;

    // per-request control handed from the input stage to the edge unit
    typedef struct packed
    {
        req_kind_t kind;
        logic      emit_a;
        logic      emit_b;
        logic      a_left;
        logic      a_right;
        logic      b_left;
        logic      top_ok;
        logic      bot_ok;
        logic      a_row_last;
        logic      a_frame_last;
        slot_t     slot_above;
        slot_t     slot_prev;
    } ctl_t;

    typedef struct packed
    {
        logic       frame_last;
        logic       row_last;
        logic [7:0] edge_value;
    } result_t;

    function automatic slot_t slot_inc(input slot_t s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic slot_t slot_dec(input slot_t s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

endpackage

@@ hw/rtl/neighbor_max_abs_diff_edge_filter.sv @@
// neighbor_max_abs_diff_edge_filter: top level, frame counters, line stores and result path
// depends on nmd_pkg, nmd_line_ram, nmd_edge_unit, nmd_result_fifo
`timescale 1ns / 1ps
//
//  channel   dir   handshake              payload
//  s_axis    in    tvalid / tready        tdata = pixel_value, tuser = req_type
//  m_axis    out   tvalid / tready        tdata = edge_value, tlast = row_last,
//                                         tuser = frame_last
//  cfg       in    cfg_wr_en              cfg_wr_data = image_width
//
//  one request per cycle while tready is high; a result passes the input stage (line store read)
//  and then the four-entry result queue before it leaves
//  a row-end pixel gives up to two results, a drain request one or none, other pixels one or none
//  tready drops only while a request waits and the result queue holds three or more
//  reset clears the counters and the queue; line stores need no clearing pass

module neighbor_max_abs_diff_edge_filter #(
    parameter int WIDTH_MAX  = nmd_pkg::NMD_WIDTH_MAX,
    parameter int PIXEL_BITS = nmd_pkg::NMD_PIXEL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [nmd_pkg::NMD_CFG_BITS-1:0] cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] pixel_value
    input  logic                             s_axis_tuser,   // [0] req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] edge_value
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser    // [0] frame_last
);

    import nmd_pkg::*;

    localparam int AW    = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
    localparam int CNT_W = ($clog2(WIDTH_MAX + 1) > NMD_CFG_BITS) ?
                           $clog2(WIDTH_MAX + 1) : NMD_CFG_BITS;

    logic [NMD_CFG_BITS-1:0] width_reg;
    logic [NMD_CFG_BITS-1:0] width_next;
    logic [AW-1:0]           col_reg;
    logic [AW-1:0]           col_next;
    logic [1:0]              rows_reg;
    logic [1:0]              rows_next;
    slot_t                   slot_reg;
    slot_t                   slot_next;
    logic [AW-1:0]           drain_reg;
    logic [AW-1:0]           drain_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    ctl_t                    ctl_reg;
    ctl_t                    ctl_next;
    logic [PIXEL_BITS-1:0]   px_reg;

    logic                    accept;
    logic                    fire;
    logic                    room_two;
    logic                    is_drain;
    logic [CNT_W-1:0]        width_ext;
    logic [CNT_W-1:0]        w_eff;
    logic                    restart;
    logic [AW-1:0]           k;
    logic [CNT_W-1:0]        k_ext;
    logic                    k_end;
    logic [1:0]              rows_px;
    slot_t                   slot_px;
    logic [CNT_W-1:0]        d_ext;
    logic                    d_end;
    logic                    drain_ok;
    logic [AW-1:0]           raddr_a;
    logic [AW-1:0]           raddr_b;
    logic [PIXEL_BITS+7:0]   px_wide;
    logic [PIXEL_BITS-1:0]   px_in;

    logic [2:0][PIXEL_BITS-1:0] col_a;
    logic [2:0][PIXEL_BITS-1:0] col_b;
    result_t                    res_a;
    result_t                    res_b;
    result_t                    out_data;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = s1_valid_reg && room_two;
    assign s_axis_tready = !s1_valid_reg || fire;

    always_comb
    begin
        is_drain  = req_kind_t'(s_axis_tuser) == REQ_DRAIN;
        px_wide   = {{PIXEL_BITS{1'b0}}, s_axis_tdata};
        px_in     = px_wide[PIXEL_BITS-1:0];

        width_ext = CNT_W'(width_reg);
        if (width_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (width_ext > CNT_W'(WIDTH_MAX))
        begin
            w_eff = CNT_W'(WIDTH_MAX);
        end
        else
        begin
            w_eff = width_ext;
        end

        // a pixel arriving partway through a drain starts a new frame
        restart = drain_reg != '0;
        k       = restart ? '0 : col_reg;
        rows_px = restart ? 2'd0 : rows_reg;
        slot_px = restart ? 2'd0 : slot_reg;
        k_ext   = CNT_W'(k);
        k_end   = (k_ext + CNT_W'(1)) >= w_eff;

        d_ext    = CNT_W'(drain_reg);
        d_end    = (d_ext + CNT_W'(1)) >= w_eff;
        drain_ok = (rows_reg != 2'd0) && (col_reg == '0);

        raddr_a = is_drain ? drain_reg : k;
        raddr_b = drain_reg + AW'(1);

        width_next = cfg_wr_en ? cfg_wr_data : width_reg;
        col_next   = col_reg;
        rows_next  = rows_reg;
        slot_next  = slot_reg;
        drain_next = drain_reg;
        ctl_next   = '0;

        if (!is_drain)
        begin
            ctl_next.kind       = REQ_PIXEL;
            ctl_next.emit_a     = (rows_px != 2'd0) && (k != '0);
            ctl_next.a_left     = k_ext > CNT_W'(1);
            ctl_next.a_right    = k_ext < w_eff;
            ctl_next.emit_b     = k_end && (rows_px != 2'd0);
            ctl_next.b_left     = k != '0;
            ctl_next.top_ok     = rows_px[1];
            ctl_next.bot_ok     = 1'b1;
            ctl_next.slot_above = slot_inc(slot_px);
            ctl_next.slot_prev  = slot_dec(slot_px);
            drain_next          = '0;
            if (k_end)
            begin
                col_next  = '0;
                slot_next = slot_inc(slot_px);
                rows_next = rows_px[1] ? rows_px : rows_px + 2'd1;
            end
            else
            begin
                col_next  = k + AW'(1);
                slot_next = slot_px;
                rows_next = rows_px;
            end
        end
        else if (!drain_ok)
        begin
            // nothing complete to flush: abandon the frame quietly
            ctl_next.kind = REQ_DRAIN;
            col_next      = '0;
            rows_next     = 2'd0;
            slot_next     = 2'd0;
            drain_next    = '0;
        end
        else
        begin
            ctl_next.kind         = REQ_DRAIN;
            ctl_next.emit_a       = 1'b1;
            ctl_next.a_left       = drain_reg != '0;
            ctl_next.a_right      = !d_end;
            ctl_next.top_ok       = rows_reg[1];
            ctl_next.bot_ok       = 1'b0;
            ctl_next.a_row_last   = d_end;
            ctl_next.a_frame_last = d_end;
            ctl_next.slot_above   = slot_inc(slot_reg);
            ctl_next.slot_prev    = slot_dec(slot_reg);
            if (d_end)
            begin
                col_next   = '0;
                rows_next  = 2'd0;
                slot_next  = 2'd0;
                drain_next = '0;
            end
            else
            begin
                drain_next = drain_reg + AW'(1);
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= NMD_WIDTH_RESET;
            col_reg      <= '0;
            rows_reg     <= 2'd0;
            slot_reg     <= 2'd0;
            drain_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg   <= col_next;
                rows_reg  <= rows_next;
                slot_reg  <= slot_next;
                drain_reg <= drain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            px_reg  <= px_in;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_line
        nmd_line_ram #(
            .DEPTH  (WIDTH_MAX),
            .DATA_W (PIXEL_BITS)
        ) u_line_ram (
            .clk     (clk),
            .we      (accept && !is_drain && (slot_px == slot_t'(i))),
            .waddr   (k),
            .wdata   (px_in),
            .re      (accept),
            .raddr_a (raddr_a),
            .raddr_b (raddr_b),
            .rdata_a (col_a[i]),
            .rdata_b (col_b[i])
        );
    end

    nmd_edge_unit #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_edge_unit (
        .clk   (clk),
        .fire  (fire),
        .ctl   (ctl_reg),
        .px    (px_reg),
        .col_a (col_a),
        .col_b (col_b),
        .res_a (res_a),
        .res_b (res_b)
    );

    nmd_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_a_valid (fire && ctl_reg.emit_a),
        .in_a       (res_a),
        .in_b_valid (fire && ctl_reg.emit_b),
        .in_b       (res_b),
        .room_two   (room_two),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tdata = out_data.edge_value;
    assign m_axis_tlast = out_data.row_last;
    assign m_axis_tuser = out_data.frame_last;

endmodule

@@ hw/rtl/nmd_line_ram.sv @@
// nmd_line_ram: one line store row, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module nmd_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hw/rtl/nmd_edge_unit.sv @@
// nmd_edge_unit: 3x3 column window and the two max abs difference evaluations per request
// depends on nmd_pkg
`timescale 1ns / 1ps

module nmd_edge_unit #(
    parameter int PIXEL_BITS = nmd_pkg::NMD_PIXEL_BITS
) (
    input  logic                       clk,
    input  logic                       fire,
    input  nmd_pkg::ctl_t              ctl,
    input  logic [PIXEL_BITS-1:0]      px,
    input  logic [2:0][PIXEL_BITS-1:0] col_a,  // read port a of line stores 0..2
    input  logic [2:0][PIXEL_BITS-1:0] col_b,  // read port b of line stores 0..2
    output nmd_pkg::result_t           res_a,
    output nmd_pkg::result_t           res_b
);

    import nmd_pkg::*;

    typedef struct packed
    {
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] bot;
    } column_t;

    column_t wa_reg;
    column_t wb_reg;
    column_t wa_next;
    column_t wb_next;
    column_t col_new;
    column_t col_right;
    column_t a_l;
    column_t a_c;
    column_t a_r;

    logic [PIXEL_BITS-1:0] val_a;
    logic [PIXEL_BITS-1:0] val_b;
    logic [PIXEL_BITS+7:0] ext_a;
    logic [PIXEL_BITS+7:0] ext_b;

    function automatic logic [PIXEL_BITS-1:0] max_abs_diff(
        input column_t l,
        input column_t c,
        input column_t r,
        input logic    lok,
        input logic    rok,
        input logic    tok,
        input logic    bok
    );
        logic [PIXEL_BITS-1:0] nb [8];
        logic [7:0]            ok;
        logic [PIXEL_BITS-1:0] best;
        logic [PIXEL_BITS-1:0] d;
        nb[0] = l.top;
        nb[1] = l.mid;
        nb[2] = l.bot;
        nb[3] = c.top;
        nb[4] = c.bot;
        nb[5] = r.top;
        nb[6] = r.mid;
        nb[7] = r.bot;
        ok[0] = lok & tok;
        ok[1] = lok;
        ok[2] = lok & bok;
        ok[3] = tok;
        ok[4] = bok;
        ok[5] = rok & tok;
        ok[6] = rok;
        ok[7] = rok & bok;
        best  = '0;
        for (int i = 0; i < 8; i++)
        begin
            d = (nb[i] >= c.mid) ? nb[i] - c.mid : c.mid - nb[i];
            if (ok[i] && (d > best))
            begin
                best = d;
            end
        end
        return best;
    endfunction

    always_comb
    begin
        col_new.top   = col_a[ctl.slot_above];
        col_new.mid   = col_a[ctl.slot_prev];
        col_new.bot   = px;
        col_right.top = col_b[ctl.slot_above];
        col_right.mid = col_b[ctl.slot_prev];
        col_right.bot = '0;

        // pixel: result one column behind the incoming one; drain: result at the read column
        if (ctl.kind == REQ_DRAIN)
        begin
            a_l = wb_reg;
            a_c = col_new;
            a_r = col_right;
        end
        else
        begin
            a_l = wa_reg;
            a_c = wb_reg;
            a_r = col_new;
        end

        val_a = max_abs_diff(a_l, a_c, a_r, ctl.a_left, ctl.a_right, ctl.top_ok, ctl.bot_ok);
        // row end: the incoming column itself, no right neighbor
        val_b = max_abs_diff(wb_reg, col_new, col_new, ctl.b_left, 1'b0, ctl.top_ok,
                             ctl.bot_ok);

        ext_a = {8'd0, val_a};
        ext_b = {8'd0, val_b};

        res_a.edge_value = ext_a[7:0];
        res_a.row_last   = ctl.a_row_last;
        res_a.frame_last = ctl.a_frame_last;
        res_b.edge_value = ext_b[7:0];
        res_b.row_last   = 1'b1;
        res_b.frame_last = 1'b0;

        wa_next = fire ? wb_reg  : wa_reg;
        wb_next = fire ? col_new : wb_reg;
    end

    always_ff @(posedge clk)
    begin
        wa_reg <= wa_next;
        wb_reg <= wb_next;
    end

endmodule

@@ hw/rtl/nmd_result_fifo.sv @@
// nmd_result_fifo: small result queue taking up to two results a cycle, one out
// depends on nmd_pkg
`timescale 1ns / 1ps

module nmd_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_a_valid,
    input  nmd_pkg::result_t in_a,
    input  logic             in_b_valid,
    input  nmd_pkg::result_t in_b,
    output logic             room_two,
    output logic             out_valid,
    input  logic             out_ready,
    output nmd_pkg::result_t out_data
);

    import nmd_pkg::*;

    localparam int PTR_W = $clog2(NMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(NMD_FIFO_DEPTH + 1);

    result_t          entry_reg [NMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       push_n;
    logic             pop;

    always_comb
    begin
        pop         = out_valid && out_ready;
        push_n      = {1'b0, in_a_valid} + {1'b0, in_b_valid};
        wr_ptr_plus = wr_ptr_reg + PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    assign room_two  = count_reg <= CNT_W'(NMD_FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (in_a_valid)
        begin
            entry_reg[wr_ptr_reg] <= in_a;
            if (in_b_valid)
            begin
                entry_reg[wr_ptr_plus] <= in_b;
            end
        end
        else if (in_b_valid)
        begin
            entry_reg[wr_ptr_reg] <= in_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/nmd_checker.sv @@
// nmd_checker: port-level assertions for the edge filter, bound to the top level
// depends on neighbor_max_abs_diff_edge_filter port names
`timescale 1ns / 1ps

module nmd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // end of frame always closes a row
    a_frame_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_last without row_last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> s_axis_tready)
        else $error("not ready after reset");

    // an empty queue refills only from an accepted request that has passed the input stage
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching request");

endmodule

bind neighbor_max_abs_diff_edge_filter nmd_checker u_nmd_checker (.*);

@@ tb/sv/tb_neighbor_max_abs_diff_edge_filter.sv @@
// tb_neighbor_max_abs_diff_edge_filter: self-checking bench for the 3x3 max abs diff edge filter
// depends on nmd_pkg and neighbor_max_abs_diff_edge_filter; predicts results in-bench and
// checks every result field under directed frames, random frames and random stalls
`timescale 1ns / 1ps

module tb_neighbor_max_abs_diff_edge_filter;
    import nmd_pkg::*;

    localparam int MAX_COLS = NMD_WIDTH_MAX;

    typedef enum logic { ROW_CFG, ROW_REQ } dir_op_t;

    typedef enum logic [1:0]
    {
        FRAME_FULL,
        FRAME_DRAIN_CUT,
        FRAME_ROW_CUT,
        FRAME_STRAY
    } frame_style_t;

    typedef struct
    {
        dir_op_t                 op;
        req_kind_t               kind;
        logic [NMD_CFG_BITS-1:0] value;
        bit                      typed;
        int                      n_typed;
        result_t                 typed_res;
    } dir_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [NMD_CFG_BITS-1:0] cfg_wr_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = '0;   // [7:0] pixel_value
    logic                    s_axis_tuser = 1'b0; // [0] req_type
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [7:0]              m_axis_tdata;        // [7:0] edge_value
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;        // [0] frame_last

    // predictor state
    logic [7:0] pix_rows [3][MAX_COLS];
    int         cfg_width = int'(NMD_WIDTH_RESET);
    int         col_pos = 0;
    int         full_rows = 0;
    int         fill_slot = 0;
    int         flush_col = 0;

    result_t    step_out [$];
    result_t    edge_expect_q [$];
    result_t    want;
    dir_row_t   dir_tab [$];

    int send_idle = 0;
    int recv_stall = 0;
    int fail_count = 0;
    int req_count = 0;
    int checked_count = 0;
    int frame_count = 0;
    int width_writes = 0;

    neighbor_max_abs_diff_edge_filter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > MAX_COLS)
            return MAX_COLS;
        return cfg_width;
    endfunction

    function automatic void clear_frame();
        col_pos = 0;
        full_rows = 0;
        fill_slot = 0;
        flush_col = 0;
    endfunction

    // largest |neighbor - center| over in-image neighbors of row slot mid
    function automatic logic [7:0] neighbor_peak(int mid, int col, bit up_ok, bit down_ok,
                                                 int w);
        logic [7:0] ctr;
        logic [7:0] best;
        logic [7:0] nb;
        logic [7:0] d;
        ctr = pix_rows[mid][col];
        best = '0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if ((dr == 0 && dc == 0) || (dr < 0 && !up_ok) || (dr > 0 && !down_ok) ||
                    (dc < 0 && col == 0) || (dc > 0 && col + 1 >= w))
                    continue;
                nb = pix_rows[(mid + 3 + dr) % 3][col + dc];
                d = (nb >= ctr) ? nb - ctr : ctr - nb;
                if (d > best)
                    best = d;
            end
        end
        return best;
    endfunction

    function automatic void advance_filter(req_kind_t kind, logic [7:0] px);
        int      w;
        int      k;
        result_t r;
        w = active_width();
        step_out.delete();
        if (kind == REQ_PIXEL)
        begin
            // a pixel arriving mid-drain starts a fresh frame
            if (flush_col != 0)
                clear_frame();
            k = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
            pix_rows[fill_slot][k] = px;
            if (full_rows >= 1 && k >= 1)
            begin
                r.edge_value = neighbor_peak((fill_slot + 2) % 3, k - 1, full_rows >= 2, 1'b1, w);
                r.row_last = 1'b0;
                r.frame_last = 1'b0;
                step_out.push_back(r);
            end
            if (k + 1 >= w)
            begin
                if (full_rows >= 1)
                begin
                    r.edge_value = neighbor_peak((fill_slot + 2) % 3, k, full_rows >= 2, 1'b1, w);
                    r.row_last = 1'b1;
                    r.frame_last = 1'b0;
                    step_out.push_back(r);
                end
                col_pos = 0;
                fill_slot = (fill_slot + 1) % 3;
                if (full_rows < 2)
                    full_rows++;
            end
            else
                col_pos = k + 1;
        end
        else if (full_rows == 0 || col_pos != 0)
            clear_frame();
        else
        begin
            k = (flush_col >= MAX_COLS) ? MAX_COLS - 1 : flush_col;
            r.edge_value = neighbor_peak((fill_slot + 2) % 3, k, full_rows >= 2, 1'b0, w);
            r.row_last = (k + 1 >= w);
            r.frame_last = r.row_last;
            step_out.push_back(r);
            if (r.row_last)
                clear_frame();
            else
                flush_col = k + 1;
        end
    endfunction

    task automatic push_req(req_kind_t kind, logic [7:0] px, bit from_model = 1'b1);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= px;
        do @(posedge clk); while (!s_axis_tready);
        req_count++;
        advance_filter(kind, px);
        if (from_model)
            foreach (step_out[i])
                edge_expect_q.push_back(step_out[i]);
    endtask

    // sender holds off until every outstanding result is out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (edge_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_width(logic [NMD_CFG_BITS-1:0] val);
        wait_drained();
        // pixels that give no result may still be in flight
        repeat (8) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_width = int'(val);
        width_writes++;
    endtask

    function automatic logic [7:0] pick_pixel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(int rows, frame_style_t style);
        int w;
        int cut;
        w = active_width();
        cut = (w > 1) ? $urandom_range(1, w - 1) : 1;
        repeat (rows * w) push_req(REQ_PIXEL, pick_pixel());
        case (style)
            FRAME_FULL:
                repeat (w) push_req(REQ_DRAIN, pick_pixel());
            FRAME_DRAIN_CUT:
                repeat (cut) push_req(REQ_DRAIN, pick_pixel());
            FRAME_ROW_CUT:
            begin
                repeat ((w > 1) ? cut : 0) push_req(REQ_PIXEL, pick_pixel());
                push_req(REQ_DRAIN, pick_pixel());
            end
            default:
                push_req(REQ_DRAIN, pick_pixel());
        endcase
        frame_count++;
    endtask

    task automatic run_phase(logic [NMD_CFG_BITS-1:0] width, int idle, int stall, int budget);
        int start;
        int pick;
        // a drain left partway would go on under the new width into columns never written
        if (flush_col != 0)
        begin
            push_req(REQ_PIXEL, pick_pixel());
            push_req(REQ_DRAIN, pick_pixel());
        end
        set_width(width);
        send_idle = idle;
        recv_stall = stall;
        start = req_count;
        while (req_count - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                send_frame($urandom_range(1, 4), FRAME_FULL);
            else if (pick < 88)
                send_frame($urandom_range(1, 4), FRAME_DRAIN_CUT);
            else if (pick < 96)
                send_frame($urandom_range(1, 3), FRAME_ROW_CUT);
            else
                send_frame(0, FRAME_STRAY);
        end
    endtask

    function automatic void add_cfg(logic [NMD_CFG_BITS-1:0] val);
        dir_row_t row;
        row.op = ROW_CFG;
        row.kind = REQ_PIXEL;
        row.value = val;
        row.typed = 1'b0;
        row.n_typed = 0;
        row.typed_res = '0;
        dir_tab.push_back(row);
    endfunction

    function automatic void add_req(req_kind_t kind, logic [7:0] px, bit typed = 1'b0,
                                    int n_typed = 0, result_t res = '0);
        dir_row_t row;
        row.op = ROW_REQ;
        row.kind = kind;
        row.value = NMD_CFG_BITS'(px);
        row.typed = typed;
        row.n_typed = n_typed;
        row.typed_res = res;
        dir_tab.push_back(row);
    endfunction

    always @(posedge clk)
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (edge_expect_q.size() == 0)
            begin
                $error("unexpected result: edge_value %0d row_last %0b frame_last %0b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = edge_expect_q.pop_front();
                checked_count++;
                if (m_axis_tdata !== want.edge_value)
                begin
                    $error("edge_value: expected %0d, got %0d", want.edge_value, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.row_last)
                begin
                    $error("row_last: expected %0b, got %0b", want.row_last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.frame_last)
                begin
                    $error("frame_last: expected %0b, got %0b", want.frame_last, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        // drain right after reset: nothing complete, no result
        add_req(REQ_DRAIN, 8'h00, 1'b1, 0);
        // zero width acts as one pixel per row
        add_cfg(11'd0);
        add_req(REQ_PIXEL, 8'h00, 1'b1, 0);
        add_req(REQ_PIXEL, 8'hFF, 1'b1, 1,
                result_t'{frame_last: 1'b0, row_last: 1'b1, edge_value: 8'hFF});
        add_req(REQ_DRAIN, 8'hFF, 1'b1, 1,
                result_t'{frame_last: 1'b1, row_last: 1'b1, edge_value: 8'hFF});
        // single row frame, fully drained
        add_cfg(11'd3);
        add_req(REQ_PIXEL, 8'd10);
        add_req(REQ_PIXEL, 8'd200);
        add_req(REQ_PIXEL, 8'd37);
        repeat (3) add_req(REQ_DRAIN, 8'h5A);
        // two rows, drain cut short by a new pixel
        add_req(REQ_PIXEL, 8'd5);
        add_req(REQ_PIXEL, 8'd9);
        add_req(REQ_PIXEL, 8'd250);
        add_req(REQ_PIXEL, 8'd0);
        add_req(REQ_PIXEL, 8'd128);
        add_req(REQ_PIXEL, 8'd255);
        add_req(REQ_DRAIN, 8'hA5);
        add_req(REQ_PIXEL, 8'd60);
        // drain on a partial row abandons the frame
        add_req(REQ_DRAIN, 8'h00, 1'b1, 0);
        // width shrinks while the first row is partway in
        add_cfg(11'd6);
        add_req(REQ_PIXEL, 8'd1);
        add_req(REQ_PIXEL, 8'd2);
        add_req(REQ_PIXEL, 8'd3);
        add_cfg(11'd2);
        add_req(REQ_PIXEL, 8'd4);
        add_req(REQ_PIXEL, 8'd7);
        add_req(REQ_PIXEL, 8'd8);
        repeat (2) add_req(REQ_DRAIN, 8'h00);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == ROW_CFG)
                set_width(dir_tab[i].value);
            else
            begin
                push_req(dir_tab[i].kind, dir_tab[i].value[7:0], !dir_tab[i].typed);
                if (dir_tab[i].typed && dir_tab[i].n_typed != 0)
                    edge_expect_q.push_back(dir_tab[i].typed_res);
            end
        end

        run_phase(11'($urandom_range(0, 8)), 0, 0, 180);
        run_phase(11'($urandom_range(0, 8)), 82, 0, 180);
        run_phase(11'($urandom_range(0, 8)), 0, 82, 180);
        run_phase(11'($urandom_range(0, 8)), 30, 30, 180);

        // oversize width clamps to the full line; one row then a short drain
        set_width(11'h7FF);
        send_idle = 0;
        recv_stall = 0;
        repeat (MAX_COLS) push_req(REQ_PIXEL, pick_pixel());
        repeat (4) push_req(REQ_DRAIN, pick_pixel());
        frame_count++;

        run_phase(11'd1, 30, 30, 80);
        run_phase(11'($urandom_range(9, 40)), 0, 0, 80);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("ran %0d requests in %0d frames over %0d width writes", req_count,
                 frame_count, width_writes);
        $display("checked %0d results under sender gaps and receiver stalls", checked_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
